// File: src/srp_pkg.sv
// Types and constants of the serial register port.
// Used by the top level serial_register_port_fsm; depends on nothing.
package srp_pkg;

	localparam int unsigned ADDR_W = 7;

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_START = 4'd1;
	localparam logic [3:0] PH_BIT0  = 4'd2;
	localparam logic [3:0] PH_END   = 4'd10;

	localparam logic [7:0] CMD_IDLE  = 8'd0;
	localparam logic [7:0] CMD_WRITE = 8'd1;

	localparam logic [ADDR_W-1:0] ADDR_LOCK_FIRST = 7'h57;

	localparam logic [7:0] SET_INDEX_RESET = 8'h22;
	localparam logic [7:0] READ_DATA_RESET = 8'h23;

	localparam logic CFG_SET_INDEX = 1'b0;
	localparam logic CFG_READ_DATA = 1'b1;

	typedef struct packed {
		logic [3:0] other;
		logic       dir;
		logic       clk;
		logic       dat;
	} lines_t;

endpackage

// File: src/srp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module srp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/serial_register_port_fsm.sv
// Serial register port: start/stop detection, byte shifting, register file writes and reads.
// Depends on srp_pkg and srp_ram.
//
// Channel | Handshake            | Beat contents
// in      | in_valid / in_ready  | clock_line, data_line, direction_out, other_bits
// out     | out_valid / out_ready| data_readback, link_phase, active_index, current_command
// cfg     | cfg_we               | cfg_index, cfg_wdata
//
// One beat per cycle is sustained while the output is not stalled.
// The input register feeds the edge decode and state update into the result register.
// The register file read is registered and always addresses the index in force.
// Reset clears the port state and the entry valid bits, not the RAM or data registers.
// A stalled output holds its beat while one more input beat waits in the input register.
module serial_register_port_fsm #(
	parameter int unsigned REG_COUNT = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       clock_line,
	input  logic       data_line,
	input  logic       direction_out,
	input  logic [3:0] other_bits,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       data_readback,
	output logic [3:0] link_phase,
	output logic [7:0] active_index,
	output logic [7:0] current_command,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata
);

	import srp_pkg::*;

	localparam logic [ADDR_W:0] COUNT_L = (ADDR_W+1)'(REG_COUNT);

	lines_t           item_s1;
	logic             valid_s1;
	logic             advance;

	logic [7:0]       set_code_q;
	logic [7:0]       read_code_q;
	lines_t           last_q;
	logic [3:0]       phase_q;
	logic [7:0]       cmd_q;
	logic [7:0]       shift_q;
	logic [7:0]       index_q;
	logic [REG_COUNT-1:0] entry_valid_q;
	logic             rd_valid_q;
	logic             rd_range_q;

	logic             out_valid_q;
	logic             data_q;

	lines_t           ctl_c;
	logic [3:0]       phase_c;
	logic [7:0]       cmd_c;
	logic [7:0]       shift_c;
	logic [7:0]       index_c;
	logic             wr_c;
	logic [7:0]       wdata_c;
	logic [2:0]       bitpos;
	logic [ADDR_W-1:0] addr;
	logic [7:0]       ram_rdata;
	logic [7:0]       rd_byte;
	logic             ram_we;
	logic [ADDR_W-1:0] ram_raddr;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{other: other_bits, dir: direction_out, clk: clock_line, dat: data_line};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_code_q  <= SET_INDEX_RESET;
			read_code_q <= READ_DATA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SET_INDEX: set_code_q  <= cfg_wdata;
				CFG_READ_DATA: read_code_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign addr    = index_q[ADDR_W-1:0];
	assign rd_byte = (rd_valid_q && rd_range_q) ? ram_rdata : 8'd0;
	assign bitpos  = 3'(phase_q - PH_BIT0);

	always_comb begin
		ctl_c   = item_s1;
		phase_c = phase_q;
		cmd_c   = cmd_q;
		shift_c = shift_q;
		index_c = index_q;
		wr_c    = 1'b0;
		wdata_c = shift_q;
		if (phase_q == PH_IDLE) begin
			if (last_q.clk && last_q.dat && !ctl_c.dat) begin
				phase_c = PH_START;
			end
		end else if (last_q.clk && !last_q.dat && ctl_c.dat) begin
			phase_c = PH_IDLE;
		end else if (phase_q == PH_START) begin
			if (last_q.clk && !last_q.dat && !ctl_c.clk) begin
				phase_c = PH_BIT0;
				cmd_c   = CMD_IDLE;
			end
		end else if (last_q.clk && !ctl_c.clk) begin
			if (ctl_c.dir) begin
				shift_c = shift_q | (8'(ctl_c.dat) << (3'd7 - bitpos));
				wdata_c = shift_c;
				phase_c = phase_q + 4'd1;
				if (phase_c >= PH_END) begin
					if (cmd_q == CMD_IDLE) begin
						cmd_c = shift_c;
					end else if (cmd_q == CMD_WRITE) begin
						wr_c    = (addr != '0) && (addr < ADDR_LOCK_FIRST)
							&& ({1'b0, addr} < COUNT_L);
						index_c = index_q + 8'd1;
					end else if (cmd_q == set_code_q) begin
						index_c = shift_c;
						cmd_c   = CMD_WRITE;
					end
					phase_c = PH_BIT0;
					shift_c = 8'd0;
				end
			end else if (cmd_q == read_code_q) begin
				ctl_c.dat = rd_byte[3'd7 - bitpos];
				phase_c   = phase_q + 4'd1;
				if (phase_c >= PH_END) begin
					index_c = index_q + 8'd1;
					phase_c = PH_BIT0;
				end
			end
		end else if (!ctl_c.dir) begin
			ctl_c.dat = 1'b0;
		end
	end

	assign ram_we    = advance && wr_c;
	assign ram_raddr = advance ? index_c[ADDR_W-1:0] : addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q        <= '0;
			phase_q       <= PH_IDLE;
			cmd_q         <= CMD_IDLE;
			shift_q       <= 8'd0;
			index_q       <= 8'd0;
			entry_valid_q <= '0;
			rd_valid_q    <= 1'b0;
			rd_range_q    <= 1'b0;
		end else begin
			if (advance) begin
				last_q  <= ctl_c;
				phase_q <= phase_c;
				cmd_q   <= cmd_c;
				shift_q <= shift_c;
				index_q <= index_c;
			end
			if (ram_we) begin
				entry_valid_q[addr] <= 1'b1;
			end
			rd_range_q <= ({1'b0, ram_raddr} < COUNT_L);
			rd_valid_q <= ({1'b0, ram_raddr} < COUNT_L) && entry_valid_q[ram_raddr];
		end
	end

	srp_ram #(
		.WIDTH(8),
		.DEPTH(REG_COUNT),
		.AW   (ADDR_W)
	) u_file (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr),
		.wdata(wdata_c),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q          <= ctl_c.dat;
			link_phase      <= phase_c;
			active_index    <= index_c;
			current_command <= cmd_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign data_readback = data_q;

	// A write always moves the index on, so the read port never targets the entry being written.
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_raddr != addr))
		else $error("register file read and write collide");

	a_refused_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((addr != '0) && (addr < ADDR_LOCK_FIRST)))
		else $error("write to a protected register index");

	a_idle_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |=> ((phase_q == PH_IDLE) || (phase_q == PH_START)))
		else $error("phase left idle without a start condition");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < PH_END)
		else $error("phase beyond the last bit position");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(phase_q) && $stable(index_q) && $stable(cmd_q)))
		else $error("state changed without a processed beat");

endmodule

// File: tb/serial_register_port_fsm_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for serial_register_port_fsm: line writes in, one readback beat out each.
// Shadows the port state and register file to work out readbacks the plan does not give.
// Depends on srp_pkg and the serial_register_port_fsm RTL only.
module serial_register_port_fsm_tb;
	import srp_pkg::*;

	localparam int unsigned FILE_DEPTH = 128;
	localparam int unsigned PHASES = 7;
	localparam int unsigned PHASE_BEATS = 80;
	localparam int unsigned HOLD_AFTER = 500;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic       rb;
		logic [3:0] phase;
		logic [7:0] index;
		logic [7:0] cmd;
	} port_result_t;

	typedef struct {
		lines_t       l;
		bit           typed;
		port_result_t want;
	} directed_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       clock_line = 1'b0;
	logic       data_line = 1'b0;
	logic       direction_out = 1'b0;
	logic [3:0] other_bits = 4'h0;
	logic       out_ready = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = CFG_SET_INDEX;
	logic [7:0] cfg_wdata = 8'h00;
	logic       in_ready;
	logic       out_valid;
	logic       data_readback;
	logic [3:0] link_phase;
	logic [7:0] active_index;
	logic [7:0] current_command;

	serial_register_port_fsm #(.REG_COUNT(FILE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.clock_line(clock_line), .data_line(data_line),
		.direction_out(direction_out), .other_bits(other_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.data_readback(data_readback), .link_phase(link_phase),
		.active_index(active_index), .current_command(current_command),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	lines_t       sh_lines;
	logic [3:0]   sh_phase;
	logic [7:0]   sh_cmd;
	logic [7:0]   sh_byte;
	logic [7:0]   sh_index;
	logic [7:0]   sh_file [FILE_DEPTH];
	logic [7:0]   sh_set_code;
	logic [7:0]   sh_read_code;

	lines_t       line_writes [$];
	port_result_t due_readbacks [$];
	bit           steady = 1'b0;
	bit           hold_done = 1'b0;
	int unsigned  beats_in = 0;
	int unsigned  beats_out = 0;
	int unsigned  mismatches = 0;
	int unsigned  stray_results = 0;
	int unsigned  file_writes = 0;
	int unsigned  read_bits = 0;
	int unsigned  cycles = 0;

	function automatic port_result_t apply_line_write(lines_t l);
		lines_t     ctl;
		logic       oc;
		logic       od;
		logic [2:0] k;
		logic [6:0] addr;
		ctl = l;
		oc = sh_lines.clk;
		od = sh_lines.dat;
		if (sh_phase == PH_IDLE) begin
			if (oc && od && !l.dat)
				sh_phase = PH_START;
		end else if (oc && !od && l.dat) begin
			sh_phase = PH_IDLE;
		end else if (sh_phase == PH_START) begin
			if (oc && !od && !l.clk) begin
				sh_phase = PH_BIT0;
				sh_cmd = CMD_IDLE;
			end
		end else if (oc && !l.clk) begin
			k = 3'(sh_phase - PH_BIT0);
			if (l.dir) begin
				sh_byte[3'd7 - k] = sh_byte[3'd7 - k] | l.dat;
				sh_phase = sh_phase + 4'd1;
				if (sh_phase >= PH_END) begin
					if (sh_cmd == CMD_IDLE) begin
						sh_cmd = sh_byte;
					end else if (sh_cmd == CMD_WRITE) begin
						addr = sh_index[6:0];
						if (addr != 0 && addr < ADDR_LOCK_FIRST && addr < FILE_DEPTH) begin
							sh_file[addr] = sh_byte;
							file_writes++;
						end
						sh_index = sh_index + 8'd1;
					end else if (sh_cmd == sh_set_code) begin
						sh_index = sh_byte;
						sh_cmd = CMD_WRITE;
					end
					sh_phase = PH_BIT0;
					sh_byte = '0;
				end
			end else if (sh_cmd == sh_read_code) begin
				ctl.dat = sh_file[sh_index[6:0]][3'd7 - k];
				read_bits++;
				sh_phase = sh_phase + 4'd1;
				if (sh_phase >= PH_END) begin
					sh_index = sh_index + 8'd1;
					sh_phase = PH_BIT0;
				end
			end
		end else if (!l.dir) begin
			ctl.dat = 1'b0;
		end
		sh_lines = ctl;
		return {ctl.dat, sh_phase, sh_index, sh_cmd};
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_line(bit c, bit d, bit dir);
		lines_t l;
		l.clk = c;
		l.dat = d;
		l.dir = dir;
		l.other = 4'($urandom_range(0, 15));
		line_writes.push_back(l);
	endfunction

	// A stop first, so that a frame opens from whatever state the port is in.
	function automatic void add_open();
		add_line(1'b0, 1'b0, 1'b1);
		add_line(1'b1, 1'b0, 1'b1);
		add_line(1'b1, 1'b1, 1'b1);
		add_line(1'b1, 1'b0, 1'b1);
		add_line(1'b0, 1'b0, 1'b1);
	endfunction

	function automatic void add_close();
		add_line(1'b0, 1'b0, 1'b1);
		add_line(1'b1, 1'b0, 1'b1);
		add_line(1'b1, 1'b1, 1'b1);
	endfunction

	function automatic void add_byte(logic [7:0] b, int unsigned nbits);
		for (int i = 7; i > 7 - int'(nbits); i--) begin
			add_line(1'b1, b[i], 1'b1);
			add_line(1'b0, b[i], 1'b1);
		end
	endfunction

	function automatic void add_write(logic [7:0] idx, int unsigned n);
		add_open();
		add_byte(sh_set_code, 8);
		add_byte(idx, 8);
		repeat (n)
			add_byte(8'($urandom), 8);
		if ($urandom_range(0, 4) != 0)
			add_close();
	endfunction

	function automatic void add_read(int unsigned nbits);
		add_open();
		add_byte(sh_read_code, 8);
		repeat (nbits) begin
			add_line(1'b1, 1'($urandom_range(0, 1)), 1'b0);
			add_line(1'b0, 1'b0, 1'b0);
		end
		add_close();
	endfunction

	function automatic logic [7:0] pick_index();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'h56;
			2: return {1'b0, ADDR_LOCK_FIRST} + 8'($urandom_range(0, 3));
			3: return 8'h5B;
			4: return 8'h7C + 8'($urandom_range(0, 7));
			5: return 8'hFC + 8'($urandom_range(0, 3));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void add_transaction();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			add_write(pick_index(), $urandom_range(0, 4));
		end else if (pick < 65) begin
			add_write(pick_index(), 0);
			add_read(8 * $urandom_range(1, 3)
				+ ($urandom_range(0, 3) == 0 ? $urandom_range(1, 7) : 0));
		end else if (pick < 80) begin
			add_open();
			add_byte(8'($urandom), 8);
			repeat ($urandom_range(0, 2))
				add_byte(8'($urandom), 8);
			add_close();
		end else if (pick < 90) begin
			add_open();
			add_byte(8'($urandom), $urandom_range(1, 7));
			add_close();
		end else begin
			repeat ($urandom_range(1, 8))
				add_line(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
		end
	endfunction

	function automatic directed_row_t row(int unsigned c, int unsigned d, int unsigned dir,
			logic [3:0] oth, int unsigned typed, port_result_t want);
		directed_row_t r;
		r.l.clk = 1'(c);
		r.l.dat = 1'(d);
		r.l.dir = 1'(dir);
		r.l.other = oth;
		r.typed = 1'(typed);
		r.want = want;
		return r;
	endfunction

	task automatic offer_line(lines_t l, bit typed, port_result_t want);
		port_result_t shadow;
		int unsigned g;
		in_valid <= 1'b1;
		clock_line <= l.clk;
		data_line <= l.dat;
		direction_out <= l.dir;
		other_bits <= l.other;
		do
			@(posedge clk);
		while (!in_ready);
		shadow = apply_line_write(l);
		due_readbacks.push_back(typed ? want : shadow);
		beats_in++;
		g = steady ? 0 : idle_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_codes(logic [7:0] set_v, logic [7:0] read_v);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SET_INDEX;
		cfg_wdata <= set_v;
		@(posedge clk);
		cfg_index <= CFG_READ_DATA;
		cfg_wdata <= read_v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_set_code = set_v;
		sh_read_code = read_v;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** serial_register_port_fsm: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin : check_results
		port_result_t got;
		port_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {data_readback, link_phase, active_index, current_command};
			beats_out++;
			if (due_readbacks.size() == 0) begin
				stray_results++;
				if (mismatches + stray_results <= 10)
					$display("beat %0d: result with nothing outstanding: %s",
						beats_out, $sformatf("rb=%0d phase=%0d index=%02h cmd=%02h",
						got.rb, got.phase, got.index, got.cmd));
			end else begin
				want = due_readbacks.pop_front();
				if (got.rb !== want.rb || got.phase !== want.phase ||
						got.index !== want.index || got.cmd !== want.cmd) begin
					mismatches++;
					if (mismatches + stray_results <= 10)
						$display("beat %0d: want rb=%0d phase=%0d index=%02h cmd=%02h, %s",
							beats_out, want.rb, want.phase, want.index, want.cmd,
							$sformatf("got rb=%0d phase=%0d index=%02h cmd=%02h",
							got.rb, got.phase, got.index, got.cmd));
				end
			end
		end
	end

	initial begin : receiver
		int unsigned stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && beats_out >= HOLD_AFTER) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if (!steady)
					stall = idle_len();
			end
		end
	end

	initial begin : stimulus
		directed_row_t plan [$];
		logic [7:0]    code;
		sh_lines = '0;
		sh_phase = PH_IDLE;
		sh_cmd = CMD_IDLE;
		sh_byte = '0;
		sh_index = '0;
		sh_set_code = SET_INDEX_RESET;
		sh_read_code = READ_DATA_RESET;
		foreach (sh_file[i])
			sh_file[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan.push_back(row(0, 0, 0, 4'h0, 1, {1'b0, PH_IDLE, 8'h00, CMD_IDLE}));
		plan.push_back(row(1, 1, 1, 4'hF, 1, {1'b1, PH_IDLE, 8'h00, CMD_IDLE}));
		plan.push_back(row(1, 0, 1, 4'hF, 1, {1'b0, PH_START, 8'h00, CMD_IDLE}));
		plan.push_back(row(1, 1, 1, 4'h0, 1, {1'b1, PH_IDLE, 8'h00, CMD_IDLE}));
		plan.push_back(row(1, 0, 1, 4'h0, 1, {1'b0, PH_START, 8'h00, CMD_IDLE}));
		plan.push_back(row(0, 0, 1, 4'h5, 1, {1'b0, PH_BIT0, 8'h00, CMD_IDLE}));
		plan.push_back(row(0, 1, 0, 4'hA, 1, {1'b0, PH_BIT0, 8'h00, CMD_IDLE}));
		plan.push_back(row(1, 1, 1, 4'h3, 0, '0));
		plan.push_back(row(0, 1, 1, 4'hC, 0, '0));
		plan.push_back(row(1, 0, 1, 4'h0, 0, '0));
		plan.push_back(row(0, 0, 1, 4'hF, 0, '0));
		plan.push_back(row(1, 0, 1, 4'h6, 0, '0));
		plan.push_back(row(1, 1, 1, 4'h9, 1, {1'b1, PH_IDLE, 8'h00, CMD_IDLE}));
		plan.push_back(row(1, 0, 1, 4'h0, 1, {1'b0, PH_START, 8'h00, CMD_IDLE}));
		plan.push_back(row(0, 0, 1, 4'h0, 1, {1'b0, PH_BIT0, 8'h00, CMD_IDLE}));
		plan.push_back(row(1, 0, 0, 4'h7, 0, '0));
		plan.push_back(row(0, 0, 0, 4'h8, 0, '0));
		plan.push_back(row(1, 1, 0, 4'hF, 0, '0));
		plan.push_back(row(1, 1, 1, 4'h0, 1, {1'b1, PH_IDLE, 8'h00, CMD_IDLE}));
		plan.push_back(row(1, 0, 0, 4'h0, 1, {1'b0, PH_START, 8'h00, CMD_IDLE}));
		plan.push_back(row(0, 0, 0, 4'hF, 1, {1'b0, PH_BIT0, 8'h00, CMD_IDLE}));
		plan.push_back(row(1, 1, 1, 4'hF, 0, '0));
		plan.push_back(row(1, 0, 1, 4'h0, 0, '0));
		plan.push_back(row(1, 1, 1, 4'hF, 1, {1'b1, PH_IDLE, 8'h00, CMD_IDLE}));
		foreach (plan[i])
			offer_line(plan[i].l, plan[i].typed, plan[i].want);

		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			case (ph)
				1: write_codes(8'h00, 8'hFF);
				2: write_codes(8'hFF, 8'h00);
				3: write_codes(CMD_WRITE, CMD_WRITE);
				4: write_codes(8'($urandom), 8'($urandom));
				5: write_codes(SET_INDEX_RESET, READ_DATA_RESET);
				6: begin
					code = 8'($urandom);
					write_codes(code, code);
				end
				default: ;
			endcase
			steady = (ph == 2 || ph == 5);
			if (ph == 0) begin
				add_write(8'hFF, 3);
				add_write(8'h54, 5);
				add_write(8'h59, 3);
				add_write(8'h54, 0);
				add_read(48);
				add_write(8'h7E, 0);
				add_read(24);
				add_open();
				add_byte(8'h5A, 8);
				add_byte(8'($urandom), 8);
				add_close();
				add_open();
				add_byte(8'($urandom), 3);
				add_close();
				add_write(8'h10, 1);
			end
			while (line_writes.size() < PHASE_BEATS)
				add_transaction();
			while (line_writes.size() != 0)
				offer_line(line_writes.pop_front(), 1'b0, '0);
			in_valid <= 1'b0;
			while (due_readbacks.size() != 0)
				@(posedge clk);
		end

		repeat (8) @(posedge clk);
		$display("Covered %0d line writes (%0d directed) over %0d code settings %s",
			beats_in, plan.size(), PHASES, "with one long output stall.");
		$display("Shadow file took %0d register writes and shifted out %0d read bits.",
			file_writes, read_bits);
		if (mismatches == 0 && stray_results == 0 && due_readbacks.size() == 0) begin
			$display("** serial_register_port_fsm: PASSED **");
		end else begin
			$display("%0d mismatches, %0d unexpected results, %0d outstanding.",
				mismatches, stray_results, due_readbacks.size());
			$display("** serial_register_port_fsm: FAILED **");
		end
		$finish;
	end

endmodule
